>>> rtl/linear_key_value_table_macros.svh
// Assertion macros shared by the key/value table RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property check.
`define LKVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define LKVT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LKVT_ASSERT(lbl, prop, msg)
`define LKVT_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/lkvt_pkg.sv
// Package for the key/value table: payload structs, request codes and the
// command/status structs between controller and datapath. No dependencies.
package lkvt_pkg;

    // Fixed widths of the port fields.
    localparam int LKVT_KEY_W   = 32;
    localparam int LKVT_VALUE_W = 32;
    localparam int LKVT_COUNT_W = 5;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]                     req_type;
        logic signed [LKVT_KEY_W-1:0]   key;
        logic [LKVT_VALUE_W-1:0]        value_in;
    } lkvt_req_t;

    typedef struct packed {
        logic                           found;
        logic [LKVT_VALUE_W-1:0]        value_out;
        logic                           full_error;
        logic [LKVT_COUNT_W-1:0]        entry_count;
    } lkvt_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_en;
        logic wr_insert;
        logic rd_last;
        logic wr_move;
        logic set_full;
        logic load_out;
    } lkvt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       found;
        logic       scan_hit;
        logic       scan_miss;
        logic       is_full;
    } lkvt_sts_t;

endpackage

>>> rtl/linear_key_value_table.sv
// Top level of the key/value table: controller and datapath.
// Depends on lkvt_pkg, lkvt_ctrl, lkvt_dpath (and through it lkvt_ram).
//
//   Channel  Handshake             Payload
//   req      req_valid/req_ready   req  (req_type, key, value_in)
//   rsp      rsp_valid/rsp_ready   rsp  (found, value_out, full_error, entry_count)
//
// One request at a time, scanned one stored entry per cycle; the scan ends at the first hit
// or after the last stored entry, and the unused request code skips the scan. A remove that
// hits adds a write state before the result is loaded.
// Reset clears the fill count and control state; the RAM is not cleared.
// A waiting result holds the next request in its final state until it is transferred.
module linear_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lkvt_pkg::lkvt_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lkvt_pkg::lkvt_rsp_t rsp
);
    import lkvt_pkg::*;

    lkvt_cmd_t cmd;
    lkvt_sts_t sts;

    lkvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lkvt_dpath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

>>> rtl/lkvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lkvt_dpath.sv
// Datapath of the key/value table: request and result registers, fill count,
// scan pipeline and the entry RAM. Depends on lkvt_pkg, lkvt_ram and the macros.
`include "linear_key_value_table_macros.svh"

module lkvt_dpath #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lkvt_pkg::lkvt_req_t req,
    input  lkvt_pkg::lkvt_cmd_t cmd,
    output lkvt_pkg::lkvt_sts_t sts,
    output lkvt_pkg::lkvt_rsp_t rsp
);
    import lkvt_pkg::*;

    localparam int KW = (KEY_BITS < LKVT_KEY_W) ? KEY_BITS : LKVT_KEY_W;
    localparam int VW = (VALUE_BITS < LKVT_VALUE_W) ? VALUE_BITS : LKVT_VALUE_W;
    localparam int EW = KW + VW;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_idx_reg;
    logic          found_reg;
    logic [AW-1:0] slot_reg;
    logic [VW-1:0] hit_val_reg;
    logic          full_reg;
    lkvt_rsp_t     rsp_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic          scan_issue;
    logic          match;
    logic          is_full;
    logic [CW-1:0] last_idx;

    // Scan control: one read issued per cycle, compared in the following cycle.
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign last_idx   = count_reg - CW'(1);
    assign scan_issue = cmd.scan_en && (idx_reg < count_reg);
    assign match      = cmd.scan_en && pend_reg && (ram_rdata[EW-1:VW] == key_reg);

    // RAM port selection.
    always_comb
    begin
        ram_re    = scan_issue || cmd.rd_last;
        ram_raddr = cmd.rd_last ? last_idx[AW-1:0] : idx_reg[AW-1:0];
        ram_we    = cmd.wr_insert || cmd.wr_move;
        ram_waddr = cmd.wr_move ? slot_reg : count_reg[AW-1:0];
        ram_wdata = cmd.wr_move ? ram_rdata : {key_reg, val_reg};
    end

    lkvt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers: fill count and scan pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_insert)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.wr_move)
            begin
                count_reg <= last_idx;
            end

            if (cmd.load_req)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
        end
    end

    // Request, hit and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= req.req_type;
            key_reg   <= req.key[KW-1:0];
            val_reg   <= req.value_in[VW-1:0];
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (match)
            begin
                found_reg   <= 1'b1;
                slot_reg    <= pend_idx_reg;
                hit_val_reg <= ram_rdata[VW-1:0];
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
        end

        if (scan_issue)
        begin
            pend_idx_reg <= idx_reg[AW-1:0];
        end

        if (cmd.load_out)
        begin
            rsp_reg.found       <= found_reg;
            rsp_reg.value_out   <= (op_reg == REQ_LOOKUP && found_reg) ?
                                   LKVT_VALUE_W'(hit_val_reg) : '0;
            rsp_reg.full_error  <= full_reg;
            rsp_reg.entry_count <= LKVT_COUNT_W'(count_reg);
        end
    end

    // Status back to the controller.
    always_comb
    begin
        sts.op        = op_reg;
        sts.found     = found_reg;
        sts.scan_hit  = match;
        sts.scan_miss = cmd.scan_en && !pend_reg && (idx_reg >= count_reg);
        sts.is_full   = is_full;
    end

    assign rsp = rsp_reg;

    `LKVT_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "fill count beyond capacity")
    `LKVT_ASSERT_IMPLIES(a_insert_room, cmd.wr_insert, !is_full, "insert into a full table")
    `LKVT_ASSERT_IMPLIES(a_move_after_read, cmd.wr_move, $past(cmd.rd_last),
        "move written without a read of the last entry")

endmodule

>>> rtl/lkvt_ctrl.sv
// Controller of the key/value table: sequences accept, scan, update and
// result transfer. Depends on lkvt_pkg and the macros.
`include "linear_key_value_table_macros.svh"

module lkvt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  lkvt_pkg::lkvt_sts_t sts,
    output lkvt_pkg::lkvt_cmd_t cmd
);
    import lkvt_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        DECIDE,
        RM_WRITE,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = SCAN;
                end
            end
            SCAN:
            begin
                if (!(sts.op inside {REQ_INSERT, REQ_REMOVE, REQ_LOOKUP}))
                begin
                    state_next = DECIDE;
                end
                else
                begin
                    cmd.scan_en = 1'b1;
                    if (sts.scan_hit || sts.scan_miss)
                    begin
                        state_next = DECIDE;
                    end
                end
            end
            DECIDE:
            begin
                state_next = FINISH;
                case (sts.op)
                    REQ_INSERT:
                    begin
                        if (!sts.found)
                        begin
                            if (sts.is_full)
                            begin
                                cmd.set_full = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_insert = 1'b1;
                            end
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (sts.found)
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = RM_WRITE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            RM_WRITE:
            begin
                cmd.wr_move = 1'b1;
                state_next  = FINISH;
            end
            FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = rsp_valid_reg;

    `LKVT_ASSERT_IMPLIES(a_no_overwrite, cmd.load_out, !rsp_valid_reg || rsp_ready,
        "result overwritten before transfer")
    `LKVT_ASSERT_IMPLIES(a_valid_from_finish, $rose(rsp_valid_reg),
        $past(state_reg) == FINISH, "result valid raised outside finish")

endmodule
